>>> src/fphh_pkg.sv
// Package: shared constants, beat types and control structs for the feature hash histogram.
`timescale 1ns / 1ps
package fphh_pkg;

    localparam int RADIUS_DEF     = 2;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_W      = 12;
    localparam int LIM_W      = 13;
    localparam int ROW_W      = 11;
    localparam int POS_W      = 11;
    localparam int HASH_W     = 16;
    localparam int HIST_DEPTH = 65536;
    localparam int TOT_W      = 23;
    localparam int MAX_HEIGHT = 2048;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic              is_summary;
        logic              last;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [HASH_W-1:0] win_hash;
        logic [15:0]       hash_count;
        logic              collision;
        logic [TOT_W-1:0]  feature_total;
        logic [TOT_W-1:0]  collision_total;
    } t_out_item;

    typedef struct packed {
        logic             fs;
        logic             feat;
        logic             sum;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_meta;

    typedef struct packed {
        logic busy;
        logic dirty;
    } t_hist_status;

endpackage

>>> src/feature_point_hash_histogram.sv
// Top level: position tracking, line memory, window, hash pipeline, result queue.
`timescale 1ns / 1ps
// Takes one pixel per cycle. Each pixel goes through a fixed pipeline of line
// memory read, window shift, the hash at eight bytes per stage, histogram read
// and write-back. Results leave through a queue; the input stalls only when the
// queue could not hold what the pipeline may still produce. A beat with
// frame_start waits until the pipeline is empty and, when the histogram was
// written since the last clear, for a clearing pass over all 65536 entries; the
// same pass runs after reset. Configuration writes are taken at once.
module feature_point_hash_histogram
    import fphh_pkg::*;
#(
    parameter int RADIUS     = RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int WIN   = 2 * RADIUS + 1;
    localparam int NWIN  = WIN * WIN;
    localparam int NHS   = (NWIN + 7) / 8;
    localparam int LAT   = NHS + 4;
    localparam int IFW   = $clog2(LAT + 2);
    localparam int FDEP  = 1 << $clog2(2 * LAT + 4);
    localparam int FAW   = $clog2(FDEP);
    localparam int CBITS = $clog2(MAX_WIDTH);
    localparam int MW    = $clog2(WIN);

    typedef logic [NWIN-1:0][7:0] t_win;
    typedef logic [WIN-1:0][7:0]  t_col;

    // configuration
    logic [CFG_W-1:0] r_iw, r_ih;
    logic [LIM_W-1:0] w, h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw <= CFG_W'(1920);
            r_ih <= CFG_W'(1080);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_iw <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_ih <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_iw == '0)                             w = LIM_W'(1);
        else if (LIM_W'(r_iw) > LIM_W'(MAX_WIDTH))  w = LIM_W'(MAX_WIDTH);
        else                                        w = LIM_W'(r_iw);
        if (r_ih == '0)                             h = LIM_W'(1);
        else if (LIM_W'(r_ih) > LIM_W'(MAX_HEIGHT)) h = LIM_W'(MAX_HEIGHT);
        else                                        h = LIM_W'(r_ih);
    end

    // accept control
    t_hist_status      hist_st;
    logic              hist_done;
    logic [1:0]        hist_nres;
    t_out_item         hist_res0, hist_res1;
    logic [IFW-1:0]    r_infl;
    logic [FAW:0]      r_fc;
    logic              accept, space, fs_block, clr_req, pop;

    always_comb begin
        space    = (32'(r_fc) + 2 * (32'(r_infl) + 1)) <= FDEP;
        fs_block = i_in.frame_start && (r_infl != '0 || hist_st.dirty);
        clr_req  = i_in_valid && i_in.frame_start && r_infl == '0
                   && hist_st.dirty && !hist_st.busy;
        o_in_ready = !hist_st.busy && !fs_block && space;
        accept   = i_in_valid && o_in_ready;
    end

    // position
    logic [CBITS-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [MW-1:0]    r_rm;
    logic [CBITS-1:0] c;
    logic [ROW_W-1:0] rw;
    logic [MW-1:0]    m;
    logic [LIM_W-1:0] rinc, cinc;
    logic [CBITS-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [MW-1:0]    n_rm, m_up;
    t_meta            meta0;

    always_comb begin
        c    = r_col;
        rw   = r_row;
        m    = r_rm;
        rinc = LIM_W'(r_row);
        if (i_in.frame_start) begin
            c  = '0;
            rw = '0;
            m  = '0;
        end else begin
            if (LIM_W'(r_col) >= w) begin
                c    = '0;
                rinc = LIM_W'(r_row) + 1'b1;
                m    = (r_rm == MW'(WIN - 1)) ? '0 : r_rm + 1'b1;
            end
            if (rinc >= h) begin
                rw = '0;
                m  = '0;
            end else begin
                rw = ROW_W'(rinc);
            end
        end
        m_up  = (m == MW'(WIN - 1)) ? '0 : m + 1'b1;
        cinc  = LIM_W'(c) + 1'b1;
        n_col = CBITS'(cinc);
        n_row = rw;
        n_rm  = m;
        if (cinc >= w) begin
            n_col = '0;
            if (LIM_W'(rw) + 1'b1 >= h) begin
                n_row = '0;
                n_rm  = '0;
            end else begin
                n_row = rw + 1'b1;
                n_rm  = m_up;
            end
        end
        meta0.fs    = i_in.frame_start;
        meta0.feat  = 32'(c) >= 2 * RADIUS && 32'(rw) >= 2 * RADIUS;
        meta0.sum   = LIM_W'(c) == w - 1'b1 && LIM_W'(rw) == h - 1'b1;
        meta0.pos_x = POS_W'(32'(c) - RADIUS);
        meta0.pos_y = POS_W'(32'(rw) - RADIUS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_rm  <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_rm  <= n_rm;
        end
    end

    // line memory: one lane per line slot
    t_col          r_line [MAX_WIDTH];
    t_col          r_rd0;
    logic          r_v0, r_v1;
    t_meta         r_m0, r_m1;
    logic [7:0]    r_px0;
    logic [MW-1:0] r_lane0;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line[c][m] <= i_in.pixel;
            r_rd0        <= r_line[c];
        end
        r_m0    <= meta0;
        r_px0   <= i_in.pixel;
        r_lane0 <= m;
        r_m1    <= r_m0;
    end

    // window
    t_win r_win, n_win;
    t_col newcol;

    always_comb begin
        logic [MW:0]   s;
        logic [MW-1:0] ln;
        for (int r = 0; r < WIN; r++) begin
            s  = (MW + 1)'(r_lane0) + (MW + 1)'(r + 1);
            ln = (s >= (MW + 1)'(WIN)) ? MW'(s - (MW + 1)'(WIN)) : MW'(s);
            newcol[r] = (r == WIN - 1) ? r_px0 : r_rd0[ln];
        end
        for (int r = 0; r < WIN; r++) begin
            for (int k = 0; k < WIN; k++) begin
                n_win[r * WIN + k] = (k < WIN - 1) ? r_win[r * WIN + k + 1] : newcol[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
        end else begin
            r_v0 <= accept;
            r_v1 <= r_v0;
            if (r_v0) begin
                r_win <= n_win;
            end
        end
    end

    // hash pipeline, eight bytes per stage
    logic [HASH_W-1:0] r_hv   [NHS];
    t_win              r_hw   [NHS];
    t_meta             r_hm   [NHS];
    logic              r_hvld [NHS];

    function automatic logic [HASH_W-1:0] hash_chunk(
        input logic [HASH_W-1:0] h_in,
        input t_win              wv,
        input int                base
    );
        logic [HASH_W-1:0] hh;
        hh = h_in;
        for (int j = 0; j < 8; j++) begin
            if (base + j < NWIN) begin
                hh = ((hh << 5) + hh) ^ HASH_W'(wv[base + j]);
            end
        end
        return hh;
    endfunction

    logic [7:0] ctr;
    logic       cmp;
    t_meta      meta1;

    always_comb begin
        ctr = r_win[RADIUS * WIN + RADIUS];
        cmp = ctr > r_win[RADIUS * WIN + RADIUS - 1]
              && ctr > r_win[(RADIUS - 1) * WIN + RADIUS]
              && ctr < r_win[(RADIUS - 1) * WIN + RADIUS - 1]
              && ctr > r_win[(RADIUS - 1) * WIN + RADIUS + 1]
              && ctr > r_win[(RADIUS + 1) * WIN + RADIUS - 1];
        meta1      = r_m1;
        meta1.feat = r_m1.feat && cmp;
    end

    for (genvar k = 0; k < NHS; k++) begin : g_hash
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_hv[k] <= hash_chunk('0, r_win, 0);
                r_hw[k] <= r_win;
                r_hm[k] <= meta1;
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_hvld[k] <= 1'b0;
                else          r_hvld[k] <= r_v1;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_hv[k] <= hash_chunk(r_hv[k-1], r_hw[k-1], 8 * k);
                r_hw[k] <= r_hw[k-1];
                r_hm[k] <= r_hm[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_hvld[k] <= 1'b0;
                else          r_hvld[k] <= r_hvld[k-1];
            end
        end
    end

    fphh_hist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_v      (r_hvld[NHS-1]),
        .i_hash   (r_hv[NHS-1]),
        .i_meta   (r_hm[NHS-1]),
        .i_clr    (clr_req),
        .o_status (hist_st),
        .o_done   (hist_done),
        .o_nres   (hist_nres),
        .o_res0   (hist_res0),
        .o_res1   (hist_res1)
    );

    // result queue
    t_out_item      r_fifo [FDEP];
    logic [FAW-1:0] r_wp, r_rp;

    assign o_out_valid = r_fc != '0;
    assign o_out       = r_fifo[r_rp];
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (hist_nres != 2'd0) begin
            r_fifo[r_wp] <= hist_res0;
        end
        if (hist_nres == 2'd2) begin
            r_fifo[r_wp + 1'b1] <= hist_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fc   <= '0;
            r_infl <= '0;
        end else begin
            r_wp   <= r_wp + FAW'(hist_nres);
            r_rp   <= r_rp + FAW'(pop);
            r_fc   <= r_fc + (FAW + 1)'(hist_nres) - (FAW + 1)'(pop);
            r_infl <= r_infl + IFW'(accept) - IFW'(hist_done);
        end
    end

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fc) <= FDEP)
        else $error("result queue overflow");

    a_fs_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.frame_start) |-> (r_infl == '0 && !hist_st.dirty && !hist_st.busy))
        else $error("frame start taken with histogram not clear");

    a_done_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_done |-> r_infl != '0)
        else $error("item left pipeline that was never counted");

endmodule

>>> src/fphh_hist.sv
// Histogram memory: read-modify-write of counts, frame totals, clearing pass.
`timescale 1ns / 1ps
module fphh_hist
    import fphh_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_v,
    input  logic [HASH_W-1:0] i_hash,
    input  t_meta             i_meta,
    input  logic              i_clr,
    output t_hist_status      o_status,
    output logic              o_done,
    output logic [1:0]        o_nres,
    output t_out_item         o_res0,
    output t_out_item         o_res1
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TOT_W-1:0]      TOT_MAX = {TOT_W{1'b1}};
    localparam int                    HAW     = $clog2(HIST_DEPTH);

    logic [COUNT_BITS-1:0] r_hist [HIST_DEPTH];
    logic [COUNT_BITS-1:0] r_rd;
    logic                  r_rv;
    t_meta                 r_rmeta;
    logic [HASH_W-1:0]     r_rhash;
    logic                  r_fwd_v;
    logic [HASH_W-1:0]     r_fwd_a;
    logic [COUNT_BITS-1:0] r_fwd_d;
    logic [TOT_W-1:0]      r_ftot, r_ctot;
    logic                  r_busy, r_dirty;
    logic [HAW-1:0]        r_clr;

    logic [COUNT_BITS-1:0] cur, n_cnt;
    logic [TOT_W-1:0]      base_f, base_c, n_ftot, n_ctot;
    logic                  feat, coll, wr_en;

    always_comb begin
        cur    = (r_fwd_v && r_fwd_a == r_rhash) ? r_fwd_d : r_rd;
        n_cnt  = (cur == CNT_MAX) ? cur : cur + 1'b1;
        feat   = r_rv && r_rmeta.feat;
        coll   = n_cnt > COUNT_BITS'(1);
        wr_en  = feat;
        base_f = r_rmeta.fs ? '0 : r_ftot;
        base_c = r_rmeta.fs ? '0 : r_ctot;
        n_ftot = (feat && base_f != TOT_MAX) ? base_f + 1'b1 : base_f;
        n_ctot = (feat && coll && base_c != TOT_MAX) ? base_c + 1'b1 : base_c;
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_hist[r_clr] <= '0;
        end else if (wr_en) begin
            r_hist[r_rhash] <= n_cnt;
        end
        r_rd    <= r_hist[i_hash];
        r_rmeta <= i_meta;
        r_rhash <= i_hash;
        r_fwd_a <= r_rhash;
        r_fwd_d <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv    <= 1'b0;
            r_fwd_v <= 1'b0;
            r_ftot  <= '0;
            r_ctot  <= '0;
            r_busy  <= 1'b1;
            r_dirty <= 1'b1;
            r_clr   <= '0;
        end else begin
            r_rv    <= i_v;
            r_fwd_v <= wr_en;
            if (r_rv) begin
                r_ftot <= n_ftot;
                r_ctot <= n_ctot;
            end
            if (r_busy) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == {HAW{1'b1}}) begin
                    r_busy  <= 1'b0;
                    r_dirty <= 1'b0;
                end
            end else if (i_clr) begin
                r_busy <= 1'b1;
            end else if (wr_en) begin
                r_dirty <= 1'b1;
            end
        end
    end

    t_out_item res_feat, res_sum;

    always_comb begin
        res_feat                 = '0;
        res_feat.last            = !r_rmeta.sum;
        res_feat.pos_x           = r_rmeta.pos_x;
        res_feat.pos_y           = r_rmeta.pos_y;
        res_feat.win_hash        = r_rhash;
        res_feat.hash_count      = (32'(n_cnt) > 32'hFFFF) ? 16'hFFFF : 16'(n_cnt);
        res_feat.collision       = coll;
        res_sum                  = '0;
        res_sum.is_summary       = 1'b1;
        res_sum.last             = 1'b1;
        res_sum.feature_total    = n_ftot;
        res_sum.collision_total  = n_ctot;
    end

    assign o_res0          = feat ? res_feat : res_sum;
    assign o_res1          = res_sum;
    assign o_nres          = r_rv ? (2'(feat) + 2'(r_rmeta.sum)) : 2'd0;
    assign o_done          = r_rv;
    assign o_status.busy   = r_busy;
    assign o_status.dirty  = r_dirty;

endmodule

>>> tb/sv/feature_point_hash_histogram_tb.sv
// Testbench: feature point hash histogram, self-checking against a built-in predictor.
`timescale 1ns / 1ps
module feature_point_hash_histogram_tb;
    import fphh_pkg::*;

    localparam int WIN       = 2 * RADIUS_DEF + 1;
    localparam int CTR       = RADIUS_DEF * WIN + RADIUS_DEF;
    localparam int TOT_MAX   = (1 << TOT_W) - 1;
    localparam int CNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
    localparam int SETTLE    = 24;
    localparam int LIMIT     = 6_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_beat = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_beat;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    feature_point_hash_histogram u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [7:0]   line_mem [WIN][MAX_WIDTH_DEF];
    logic [7:0]   win_px [WIN*WIN];
    int unsigned  hist_cnt [HIST_DEPTH];
    int unsigned  col_pos, row_pos, feat_total, coll_total;
    logic [CFG_W-1:0] width_reg = 12'd1920;
    logic [CFG_W-1:0] height_reg = 12'd1080;

    t_out_item    expected_q [$];
    int unsigned  mismatches, pixels_sent, results_seen, features_seen, summaries_seen;
    int unsigned  in_gap_pct, out_stall_pct, hold_cycles, cycles, fs_left;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic predict_pixel(t_in_item it);
        int unsigned w, h;
        logic [15:0] hv;
        int unsigned cnt;
        logic [7:0] c;
        t_out_item r;
        t_out_item res [$];
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (it.frame_start) begin
            hist_cnt = '{default: 0};
            feat_total = 0;
            coll_total = 0;
            col_pos = 0;
            row_pos = 0;
        end else begin
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
        end
        line_mem[row_pos % WIN][col_pos] = it.pixel;
        for (int rr = 0; rr < WIN; rr++) begin
            for (int cc = 0; cc < WIN - 1; cc++) win_px[rr*WIN+cc] = win_px[rr*WIN+cc+1];
            win_px[rr*WIN+WIN-1] = line_mem[(row_pos + rr + 1) % WIN][col_pos];
        end
        if (col_pos >= 2 * RADIUS_DEF && row_pos >= 2 * RADIUS_DEF) begin
            c = win_px[CTR];
            if (c > win_px[CTR-1] && c > win_px[CTR-WIN] && c < win_px[CTR-WIN-1] &&
                c > win_px[CTR-WIN+1] && c > win_px[CTR+WIN-1]) begin
                hv = '0;
                for (int i = 0; i < WIN * WIN; i++) hv = 16'((hv * 33) ^ win_px[i]);
                cnt = hist_cnt[hv];
                if (cnt < CNT_MAX) cnt++;
                hist_cnt[hv] = cnt;
                if (cnt > 1 && coll_total < TOT_MAX) coll_total++;
                if (feat_total < TOT_MAX) feat_total++;
                r = '0;
                r.pos_x = POS_W'(col_pos - RADIUS_DEF);
                r.pos_y = POS_W'(row_pos - RADIUS_DEF);
                r.win_hash = hv;
                r.hash_count = 16'(cnt);
                r.collision = cnt > 1;
                res.push_back(r);
                features_seen++;
            end
        end
        if (col_pos == w - 1 && row_pos == h - 1) begin
            r = '0;
            r.is_summary = 1'b1;
            r.feature_total = TOT_W'(feat_total);
            r.collision_total = TOT_W'(coll_total);
            res.push_back(r);
            summaries_seen++;
        end
        if (res.size() > 0) res[$].last = 1'b1;
        foreach (res[i]) expected_q.push_back(res[i]);
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // one pixel beat
    task automatic send_pixel(logic [7:0] px, logic fs);
        @(negedge i_clk);
        while ($urandom_range(99) < in_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat.pixel <= px;
        in_beat.frame_start <= fs;
        do @(posedge i_clk); while (!in_ready);
        predict_pixel('{pixel: px, frame_start: fs});
        pixels_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    endtask

    // full frame; tiled content makes windows repeat so collisions show up
    task automatic send_frame(logic fs, int unsigned tiled_pct);
        int unsigned w, h, per;
        logic [7:0] tile [36];
        logic [7:0] px;
        logic nfs;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        per = $urandom_range(3, 6);
        foreach (tile[i]) tile[i] = 8'($urandom);
        for (int i = 0; i < w * h; i++) begin
            px = ($urandom_range(99) < tiled_pct) ? tile[(i % w % per) * 6 + (i / w % per)]
                                                  : 8'($urandom);
            nfs = (i == 0) && fs;
            if (!nfs && fs_left > 0 && $urandom_range(199) == 0) begin
                nfs = 1'b1;
                fs_left--;
            end
            send_pixel(px, nfs);
        end
        while (col_pos != 0 || row_pos != 0) send_pixel(8'($urandom), 1'b0);
    endtask

    task automatic test_tiny_frames();
        set_size(3, 3);
        send_frame(1'b1, 0);
        set_size(0, 0);
        repeat (3) send_pixel(8'($urandom), 1'b0);
    endtask

    task automatic test_feature_window();
        logic [7:0] img [25];
        foreach (img[i]) img[i] = 8'd100;
        img[12] = 8'd150;
        img[11] = 8'd0;
        img[6]  = 8'd255;
        set_size(5, 5);
        for (int k = 0; k < 2; k++)
            foreach (img[i]) send_pixel(img[i], k == 0 && i == 0);
    endtask

    // register values beyond the maximum, checked on partial frames
    task automatic test_size_extremes();
        in_gap_pct = 0;
        out_stall_pct = 0;
        set_size(4095, 5);
        for (int i = 0; i < 24; i++) send_pixel(8'($urandom), i == 0);
        set_size(3, 4095);
        repeat (16) send_pixel(8'($urandom), 1'b0);
    endtask

    task automatic test_midframe_change();
        set_size(12, 10);
        for (int i = 0; i < 40; i++) send_pixel(8'($urandom), i == 0);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(7));
        repeat (30) send_pixel(8'($urandom), 1'b0);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(6));
        while (col_pos != 0 || row_pos != 0) send_pixel(8'($urandom), 1'b0);
    endtask

    // one-pixel frames give a result per beat, so the queue fills during the hold
    task automatic test_backpressure();
        in_gap_pct = 0;
        out_stall_pct = 0;
        set_size(0, 0);
        hold_cycles = 400;
        repeat (60) send_pixel(8'($urandom), 1'b0);
        set_size(8, 6);
        hold_cycles = 400;
        send_frame(1'b1, 80);
        wait_idle();
    endtask

    task automatic test_random(int unsigned gap, int unsigned stall, int unsigned n);
        int unsigned start;
        in_gap_pct = gap;
        out_stall_pct = stall;
        start = pixels_sent;
        while (pixels_sent - start < n) begin
            if ($urandom_range(9) == 0) set_size($urandom_range(3, 4), $urandom_range(3, 6));
            else set_size($urandom_range(5, 16), $urandom_range(5, 12));
            if (fs_left > 0 && $urandom_range(3) == 0) begin
                fs_left--;
                send_frame(1'b1, 70);
            end else begin
                send_frame(1'b0, 70);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= $urandom_range(99) >= out_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", out_beat);
            end else if (out_beat !== expected_q[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", expected_q[0], out_beat);
                void'(expected_q.pop_front());
            end else begin
                void'(expected_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        line_mem = '{default: '{default: 8'd0}};
        win_px = '{default: 8'd0};
        hist_cnt = '{default: 0};
        {col_pos, row_pos, feat_total, coll_total} = '0;
        {mismatches, pixels_sent, results_seen, features_seen, summaries_seen} = '0;
        {in_gap_pct, out_stall_pct, hold_cycles, cycles} = '0;
        fs_left = 5;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_tiny_frames();
        test_feature_window();
        test_size_extremes();
        test_midframe_change();
        test_backpressure();
        test_random(0, 0, 70);
        test_random(66, 0, 70);
        test_random(0, 66, 70);
        test_random(9, 9, 70);
        wait_idle();

        $display("run: %0d pixels, %0d results (%0d feature points, %0d frame totals)",
                 pixels_sent, results_seen, features_seen, summaries_seen);
        $display("sizes 0..4095 incl. clamping, mid-frame resize, back-pressure; %0d mismatches",
                 mismatches);
        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
